// ===== design/im2col_patch_index_generator_defines.svh =====
// Assertion macros shared by the im2col patch index generator.
// Depends on nothing; taken in by the top level with `include.
`ifndef IM2COL_PATCH_INDEX_GENERATOR_DEFINES_SVH
`define IM2COL_PATCH_INDEX_GENERATOR_DEFINES_SVH

// same-cycle implication, checked outside reset
`define I2C_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define I2C_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/i2c_pkg.sv =====
// Shared types, constants and register codes of the im2col patch index generator.
// Depends on nothing; used by every module of the block.
package i2c_pkg;

    localparam int MAX_KERNEL_SIDE = 8;

    localparam int REG_W      = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int COORD_W    = 18;
    localparam int MUL_A_W    = 24;
    localparam int MUL_B_W    = 13;
    localparam int PROD_W     = MUL_A_W + MUL_B_W;
    localparam int INDEX_W    = 34;
    localparam int CR_W       = 23;

    localparam logic [CFG_IDX_W-1:0] REG_KH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KW = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PW = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SH = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SW = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DH = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_DW = 3'd7;

    typedef struct packed {
        logic [REG_W-1:0] kernel_height;
        logic [REG_W-1:0] kernel_width;
        logic [REG_W-1:0] pad_height;
        logic [REG_W-1:0] pad_width;
        logic [REG_W-1:0] stride_height;
        logic [REG_W-1:0] stride_width;
        logic [REG_W-1:0] dilation_height;
        logic [REG_W-1:0] dilation_width;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        kernel_height:   4'd3,
        kernel_width:    4'd3,
        pad_height:      4'd0,
        pad_width:       4'd0,
        stride_height:   4'd1,
        stride_width:    4'd1,
        dilation_height: 4'd1,
        dilation_width:  4'd1
    };

    typedef struct packed {
        logic [9:0]  channel;
        logic [11:0] out_row;
        logic [11:0] out_col;
        logic [12:0] img_rows;
        logic [12:0] img_cols;
    } req_word_t;

    typedef struct packed {
        logic [INDEX_W-1:0] src_index;
        logic               is_pad;
        logic               last_tap;
    } tap_word_t;

    typedef struct packed {
        logic               issue;
        logic [MUL_A_W-1:0] a;
        logic [MUL_B_W-1:0] b;
    } mul_req_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL_Y,
        S_MUL_X,
        S_MUL_C,
        S_LOAD_CR,
        S_ROW,
        S_TAP
    } seq_state_t;

endpackage

// ===== design/i2c_mul.sv =====
// Shared multiplier of the patch index generator, product registered on issue.
// Depends on i2c_pkg.
module i2c_mul
(
    input  logic                        clk,
    input  i2c_pkg::mul_req_t           req,
    output logic [i2c_pkg::PROD_W-1:0]  prod
);

    logic [i2c_pkg::PROD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        if (req.issue)
        begin
            prod_reg <= i2c_pkg::PROD_W'(req.a) * i2c_pkg::PROD_W'(req.b);
        end
    end

    assign prod = prod_reg;

endmodule

// ===== design/i2c_seq.sv =====
// Sequencer of the patch index generator: walks the kernel taps, drives the
// shared multiplier and holds the output word register. Depends on i2c_pkg.
module i2c_seq
#(
    parameter int CW = 4
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  i2c_pkg::cfg_t               cfg,
    input  logic [CW-1:0]               kern_rows,
    input  logic [CW-1:0]               kern_cols,
    input  logic                        req_valid,
    output logic                        req_ready,
    input  i2c_pkg::req_word_t          req,
    output logic                        tap_valid,
    input  logic                        tap_ready,
    output i2c_pkg::tap_word_t          tap,
    output i2c_pkg::mul_req_t           mul_req,
    input  logic [i2c_pkg::PROD_W-1:0]  prod
);

    localparam int XW = i2c_pkg::COORD_W;

    i2c_pkg::seq_state_t state_reg, state_next;
    i2c_pkg::req_word_t  req_reg, req_next;
    logic [XW-1:0]       y_reg, y_next;
    logic [XW-1:0]       x_reg, x_next;
    logic [XW-1:0]       x0_reg, x0_next;
    logic [i2c_pkg::CR_W-1:0] cr_reg, cr_next;
    logic [CW-1:0]       ky_reg, ky_next;
    logic [CW-1:0]       kx_reg, kx_next;
    i2c_pkg::tap_word_t  tap_reg, tap_next;
    logic                tap_valid_reg, tap_valid_next;

    logic accept;
    logic start;
    logic adv;
    logic row_end;
    logic last;
    logic y_in;
    logic x_in;
    logic in_image;

    assign req_ready = (state_reg == i2c_pkg::S_IDLE);
    assign accept    = req_valid && req_ready;
    assign start     = accept && (kern_rows != '0) && (kern_cols != '0);
    assign adv       = !tap_valid_reg || tap_ready;
    assign row_end   = (kx_reg == kern_cols - CW'(1));
    assign last      = row_end && (ky_reg == kern_rows - CW'(1));
    assign y_in      = !y_reg[XW-1] && (y_reg[XW-2:0] < (XW-1)'(req_reg.img_rows));
    assign x_in      = !x_reg[XW-1] && (x_reg[XW-2:0] < (XW-1)'(req_reg.img_cols));
    assign in_image  = y_in && x_in;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            i2c_pkg::S_IDLE:
            begin
                if (start)
                begin
                    state_next = i2c_pkg::S_MUL_Y;
                end
            end
            i2c_pkg::S_MUL_Y:   state_next = i2c_pkg::S_MUL_X;
            i2c_pkg::S_MUL_X:   state_next = i2c_pkg::S_MUL_C;
            i2c_pkg::S_MUL_C:   state_next = i2c_pkg::S_LOAD_CR;
            i2c_pkg::S_LOAD_CR: state_next = i2c_pkg::S_ROW;
            i2c_pkg::S_ROW:     state_next = i2c_pkg::S_TAP;
            i2c_pkg::S_TAP:
            begin
                if (adv && last)
                begin
                    state_next = i2c_pkg::S_IDLE;
                end
                else if (adv && row_end)
                begin
                    state_next = i2c_pkg::S_ROW;
                end
            end
            default:            state_next = i2c_pkg::S_IDLE;
        endcase
    end

    // datapath and multiplier issue
    always_comb
    begin
        req_next       = req_reg;
        y_next         = y_reg;
        x_next         = x_reg;
        x0_next        = x0_reg;
        cr_next        = cr_reg;
        ky_next        = ky_reg;
        kx_next        = kx_reg;
        tap_next       = tap_reg;
        tap_valid_next = tap_valid_reg && !tap_ready;
        mul_req        = '0;
        case (state_reg)
            i2c_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    req_next = req;
                end
                ky_next = '0;
                kx_next = '0;
            end
            i2c_pkg::S_MUL_Y:
            begin
                mul_req.issue = 1'b1;
                mul_req.a     = i2c_pkg::MUL_A_W'(req_reg.out_row);
                mul_req.b     = i2c_pkg::MUL_B_W'(cfg.stride_height);
            end
            i2c_pkg::S_MUL_X:
            begin
                y_next        = XW'(prod[XW-2:0]) - XW'(cfg.pad_height);
                mul_req.issue = 1'b1;
                mul_req.a     = i2c_pkg::MUL_A_W'(req_reg.out_col);
                mul_req.b     = i2c_pkg::MUL_B_W'(cfg.stride_width);
            end
            i2c_pkg::S_MUL_C:
            begin
                x0_next       = XW'(prod[XW-2:0]) - XW'(cfg.pad_width);
                x_next        = XW'(prod[XW-2:0]) - XW'(cfg.pad_width);
                mul_req.issue = 1'b1;
                mul_req.a     = i2c_pkg::MUL_A_W'(req_reg.channel);
                mul_req.b     = req_reg.img_rows;
            end
            i2c_pkg::S_LOAD_CR:
            begin
                cr_next = prod[i2c_pkg::CR_W-1:0];
            end
            i2c_pkg::S_ROW:
            begin
                // row base; only used for taps inside the image
                mul_req.issue = 1'b1;
                mul_req.a     = i2c_pkg::MUL_A_W'(cr_reg) + i2c_pkg::MUL_A_W'(y_reg[12:0]);
                mul_req.b     = req_reg.img_cols;
            end
            i2c_pkg::S_TAP:
            begin
                if (adv)
                begin
                    tap_valid_next     = 1'b1;
                    tap_next.is_pad    = !in_image;
                    tap_next.last_tap  = last;
                    tap_next.src_index = in_image
                        ? prod[i2c_pkg::INDEX_W-1:0] + i2c_pkg::INDEX_W'(x_reg[12:0])
                        : '0;
                    if (row_end)
                    begin
                        kx_next = '0;
                        ky_next = ky_reg + CW'(1);
                        x_next  = x0_reg;
                        y_next  = y_reg + XW'(cfg.dilation_height);
                    end
                    else
                    begin
                        kx_next = kx_reg + CW'(1);
                        x_next  = x_reg + XW'(cfg.dilation_width);
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= i2c_pkg::S_IDLE;
            tap_valid_reg <= 1'b0;
            ky_reg        <= '0;
            kx_reg        <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            tap_valid_reg <= tap_valid_next;
            ky_reg        <= ky_next;
            kx_reg        <= kx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        y_reg   <= y_next;
        x_reg   <= x_next;
        x0_reg  <= x0_next;
        cr_reg  <= cr_next;
        tap_reg <= tap_next;
    end

    assign tap_valid = tap_valid_reg;
    assign tap       = tap_reg;

endmodule

// ===== design/im2col_patch_index_generator.sv =====
// im2col patch index generator: accepts a request word naming a channel and
// an output position, returns one word per kernel tap, row by row.
// A config register file feeds the sequencer; the request channel is valid/ready.
// The tap channel is valid/ready too, fed from one output register.
// Tap words carry the flat source index, a padding flag and a last-tap mark.
// The first tap word is registered in state TAP, after MUL_Y, MUL_X, MUL_C, LOAD_CR and ROW.
// One shared multiplier forms both output-position products, channel*img_rows
// and one row base per kernel row, and the taps of that row then follow one
// a cycle while the receiver takes every word.
// req_ready is high only while no request is being walked.
// A request with an empty kernel is taken and yields no word.
// A stalled receiver holds the current word and freezes the walk.
// Reset empties the output register, returns to idle and loads the register
// defaults (3x3 kernel, no padding, stride and dilation of one).
// Write config only while idle.
`include "im2col_patch_index_generator_defines.svh"
module im2col_patch_index_generator
#(
    parameter int MAX_KERNEL_SIDE = i2c_pkg::MAX_KERNEL_SIDE
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [i2c_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [i2c_pkg::REG_W-1:0]      cfg_data,
    input  logic                           req_valid,
    output logic                           req_ready,
    input  i2c_pkg::req_word_t             req,
    output logic                           tap_valid,
    input  logic                           tap_ready,
    output i2c_pkg::tap_word_t             tap
);

    localparam int CW = $clog2(MAX_KERNEL_SIDE + 1);

    i2c_pkg::cfg_t     cfg_reg, cfg_next;
    logic [CW-1:0]     kern_rows;
    logic [CW-1:0]     kern_cols;
    i2c_pkg::mul_req_t mul_req;
    logic [i2c_pkg::PROD_W-1:0] prod;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                i2c_pkg::REG_KH: cfg_next.kernel_height   = cfg_data;
                i2c_pkg::REG_KW: cfg_next.kernel_width    = cfg_data;
                i2c_pkg::REG_PH: cfg_next.pad_height      = cfg_data;
                i2c_pkg::REG_PW: cfg_next.pad_width       = cfg_data;
                i2c_pkg::REG_SH: cfg_next.stride_height   = cfg_data;
                i2c_pkg::REG_SW: cfg_next.stride_width    = cfg_data;
                i2c_pkg::REG_DH: cfg_next.dilation_height = cfg_data;
                i2c_pkg::REG_DW: cfg_next.dilation_width  = cfg_data;
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= i2c_pkg::CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // saturate kernel sides
    assign kern_rows = (cfg_reg.kernel_height > i2c_pkg::REG_W'(MAX_KERNEL_SIDE))
                     ? CW'(MAX_KERNEL_SIDE) : CW'(cfg_reg.kernel_height);
    assign kern_cols = (cfg_reg.kernel_width > i2c_pkg::REG_W'(MAX_KERNEL_SIDE))
                     ? CW'(MAX_KERNEL_SIDE) : CW'(cfg_reg.kernel_width);

    i2c_mul u_mul
    (
        .clk  (clk),
        .req  (mul_req),
        .prod (prod)
    );

    i2c_seq
    #(
        .CW (CW)
    )
    u_seq
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .kern_rows   (kern_rows),
        .kern_cols   (kern_cols),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req         (req),
        .tap_valid   (tap_valid),
        .tap_ready   (tap_ready),
        .tap         (tap),
        .mul_req     (mul_req),
        .prod        (prod)
    );

    `I2C_ASSERT_NOW(a_pad_zero, clk, rst_n, tap_valid && tap.is_pad, tap.src_index == '0, "padded tap carries a non-zero index")
    `I2C_ASSERT_NEXT(a_busy_after_start, clk, rst_n, req_valid && req_ready && (kern_rows != '0) && (kern_cols != '0), !req_ready, "request taken but block still idle")
    `I2C_ASSERT_NOW(a_idle_only_last, clk, rst_n, req_ready && tap_valid, tap.last_tap, "idle while a non-final tap word waits")

endmodule

// ===== dv/tb_im2col_patch_index_generator.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the im2col patch index generator.
// Needs only i2c_pkg and the top level; predicts every tap word and checks it in order.
module tb_im2col_patch_index_generator;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int SETTLE_CYCLES = 100;
    localparam int CHUNK_ITEMS  = 30;

    logic      clk;
    logic      rst_n;
    logic      cfg_we;
    logic [i2c_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [i2c_pkg::REG_W-1:0]     cfg_data;
    logic      req_valid;
    logic      req_ready;
    i2c_pkg::req_word_t req;
    logic      tap_valid;
    logic      tap_ready;
    i2c_pkg::tap_word_t tap;

    i2c_pkg::cfg_t      model_cfg;
    i2c_pkg::tap_word_t expected_taps[$];
    i2c_pkg::tap_word_t want;
    int        send_idle_pct;
    int        recv_idle_pct;
    int        stall_left;
    int        failures;
    int        taps_checked;
    int        requests_taken;
    int        settings_used;
    int        cycle_count;

    im2col_patch_index_generator DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .tap_valid (tap_valid),
        .tap_ready (tap_ready),
        .tap       (tap)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        tap_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                tap_ready <= 1'b0;
            end
            else
                tap_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles, %0d words still awaited",
                     cycle_count, expected_taps.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic note_failure(input string what);
        failures++;
        if (failures <= 10)
            $display("%0t: %s", $realtime, what);
    endtask

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && tap_valid === 1'b1 && tap_ready === 1'b1)
        begin
            if (expected_taps.size() == 0)
                note_failure($sformatf("tap word with none awaited: index %0d pad %b last %b",
                                       tap.src_index, tap.is_pad, tap.last_tap));
            else
            begin
                want = expected_taps.pop_front();
                taps_checked++;
                if (tap.src_index !== want.src_index || tap.is_pad !== want.is_pad
                    || tap.last_tap !== want.last_tap)
                    note_failure($sformatf(
                        "tap mismatch: expected index %0d pad %b last %b, got index %0d pad %b last %b",
                        want.src_index, want.is_pad, want.last_tap,
                        tap.src_index, tap.is_pad, tap.last_tap));
            end
        end
    end

    function automatic void predict_patch(input i2c_pkg::req_word_t r);
        int        kh;
        int        kw;
        int        total;
        int        n;
        longint    chan;
        longint    rows;
        longint    cols;
        longint    y0;
        longint    x0;
        longint    y;
        longint    x;
        longint    flat;
        i2c_pkg::tap_word_t t;
        kh = (model_cfg.kernel_height > i2c_pkg::MAX_KERNEL_SIDE) ? i2c_pkg::MAX_KERNEL_SIDE
                                                                  : model_cfg.kernel_height;
        kw = (model_cfg.kernel_width > i2c_pkg::MAX_KERNEL_SIDE) ? i2c_pkg::MAX_KERNEL_SIDE
                                                                 : model_cfg.kernel_width;
        total = kh * kw;
        n = 0;
        chan = r.channel;
        rows = r.img_rows;
        cols = r.img_cols;
        y0 = r.out_row;
        x0 = r.out_col;
        y0 = y0 * longint'(model_cfg.stride_height) - longint'(model_cfg.pad_height);
        x0 = x0 * longint'(model_cfg.stride_width) - longint'(model_cfg.pad_width);
        for (int ky = 0; ky < kh; ky++)
        begin
            y = y0 + longint'(ky) * longint'(model_cfg.dilation_height);
            for (int kx = 0; kx < kw; kx++)
            begin
                x = x0 + longint'(kx) * longint'(model_cfg.dilation_width);
                n++;
                if (y >= 0 && y < rows && x >= 0 && x < cols)
                begin
                    flat = (chan * rows + y) * cols + x;
                    t.src_index = flat[i2c_pkg::INDEX_W-1:0];
                    t.is_pad = 1'b0;
                end
                else
                begin
                    t.src_index = '0;
                    t.is_pad = 1'b1;
                end
                t.last_tap = (n == total);
                expected_taps = {expected_taps, t};
            end
        end
    endfunction

    function automatic i2c_pkg::cfg_t make_cfg(input logic [3:0] kh, kw, ph, pw, sh, sw,
                                               dh, dw);
        i2c_pkg::cfg_t c;
        c.kernel_height = kh;
        c.kernel_width = kw;
        c.pad_height = ph;
        c.pad_width = pw;
        c.stride_height = sh;
        c.stride_width = sw;
        c.dilation_height = dh;
        c.dilation_width = dw;
        return c;
    endfunction

    function automatic i2c_pkg::req_word_t make_request(input logic [9:0] ch,
                                                        input logic [11:0] row,
                                                        input logic [11:0] col,
                                                        input logic [12:0] rows, cols);
        i2c_pkg::req_word_t r;
        r.channel = ch;
        r.out_row = row;
        r.out_col = col;
        r.img_rows = rows;
        r.img_cols = cols;
        return r;
    endfunction

    function automatic logic [3:0] random_side();
        if ($urandom_range(99) < 90)
            return 4'($urandom_range(i2c_pkg::MAX_KERNEL_SIDE, 1));
        return 4'($urandom_range(15));
    endfunction

    function automatic logic [3:0] random_step(input int usual_max);
        if ($urandom_range(99) < 80)
            return 4'($urandom_range(usual_max, 1));
        return 4'($urandom_range(15));
    endfunction

    function automatic i2c_pkg::cfg_t random_config();
        return make_cfg(random_side(), random_side(), 4'($urandom_range(15)),
                        4'($urandom_range(15)), random_step(4), random_step(4),
                        random_step(3), random_step(3));
    endfunction

    function automatic logic [11:0] random_position(input logic [12:0] side,
                                                    input logic [3:0] stride);
        int unsigned span;
        if ($urandom_range(9) == 0)
            return 12'($urandom_range(4095));
        span = int'(side) / ((stride == 0) ? 1 : int'(stride)) + 2;
        return 12'($urandom_range((span > 4095) ? 4095 : span));
    endfunction

    function automatic i2c_pkg::req_word_t random_request();
        i2c_pkg::req_word_t r;
        int unsigned        shape;
        r.channel = 10'($urandom_range(1023));
        shape = $urandom_range(99);
        if (shape < 70)
        begin
            r.img_rows = 13'($urandom_range(64, 1));
            r.img_cols = 13'($urandom_range(64, 1));
        end
        else if (shape < 85)
        begin
            r.img_rows = 13'($urandom_range(8191, 65));
            r.img_cols = 13'($urandom_range(8191, 65));
        end
        else if (shape < 92)
        begin
            r.img_rows = ($urandom_range(1) == 0) ? '0 : 13'($urandom_range(64, 1));
            r.img_cols = (r.img_rows != 0) ? '0 : 13'($urandom_range(8191));
        end
        else
        begin
            r.img_rows = 13'($urandom_range(8191));
            r.img_cols = 13'($urandom_range(8191));
        end
        r.out_row = random_position(r.img_rows, model_cfg.stride_height);
        r.out_col = random_position(r.img_cols, model_cfg.stride_width);
        return r;
    endfunction

    task automatic send_request(input i2c_pkg::req_word_t r);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= r;
        do
            @(posedge clk);
        while (req_ready !== 1'b1);
        predict_patch(r);
        requests_taken++;
    endtask

    task automatic wait_idle();
        req_valid <= 1'b0;
        while (expected_taps.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_config(input i2c_pkg::cfg_t c);
        logic [i2c_pkg::REG_W-1:0] vals [8];
        wait_idle();
        vals[i2c_pkg::REG_KH] = c.kernel_height;
        vals[i2c_pkg::REG_KW] = c.kernel_width;
        vals[i2c_pkg::REG_PH] = c.pad_height;
        vals[i2c_pkg::REG_PW] = c.pad_width;
        vals[i2c_pkg::REG_SH] = c.stride_height;
        vals[i2c_pkg::REG_SW] = c.stride_width;
        vals[i2c_pkg::REG_DH] = c.dilation_height;
        vals[i2c_pkg::REG_DW] = c.dilation_width;
        for (int i = 0; i < 8; i++)
        begin
            cfg_we <= 1'b1;
            cfg_index <= i2c_pkg::CFG_IDX_W'(i);
            cfg_data <= vals[i];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        model_cfg = c;
        settings_used++;
    endtask

    task automatic test_reset_defaults();
        send_request(make_request(10'd0, 12'd0, 12'd0, 13'd5, 13'd5));
        send_request(make_request(10'd1023, 12'd4095, 12'd4095, 13'd4096, 13'd4096));
        send_request(make_request(10'd512, 12'd2, 12'd3, 13'd6, 13'd7));
        wait_idle();
    endtask

    task automatic test_field_extremes();
        write_config(make_cfg(4'd3, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1));
        send_request('0);
        send_request('1);
        send_request(make_request(10'd1023, 12'd0, 12'd0, 13'd8191, 13'd8191));
        send_request(make_request(10'd7, 12'd1, 12'd1, 13'd0, 13'd9));
        send_request(make_request(10'd7, 12'd1, 12'd1, 13'd9, 13'd0));
        wait_idle();
    endtask

    task automatic test_kernel_sides();
        write_config(make_cfg(4'd0, 4'd3, 4'd0, 4'd0, 4'd1, 4'd1, 4'd1, 4'd1));
        send_request(make_request(10'd3, 12'd1, 12'd1, 13'd8, 13'd8));
        write_config(make_cfg(4'd3, 4'd0, 4'd0, 4'd0, 4'd1, 4'd1, 4'd1, 4'd1));
        send_request(make_request(10'd3, 12'd1, 12'd1, 13'd8, 13'd8));
        write_config(make_cfg(4'd15, 4'd15, 4'd2, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1));
        send_request(make_request(10'd5, 12'd0, 12'd3, 13'd9, 13'd10));
        write_config(make_cfg(4'd1, 4'd1, 4'd0, 4'd0, 4'd1, 4'd1, 4'd1, 4'd1));
        send_request(make_request(10'd9, 12'd4, 12'd6, 13'd8, 13'd8));
        wait_idle();
    endtask

    task automatic test_stride_dilation();
        write_config(make_cfg(4'd4, 4'd4, 4'd15, 4'd15, 4'd0, 4'd0, 4'd0, 4'd0));
        send_request(make_request(10'd2, 12'd100, 12'd100, 13'd20, 13'd20));
        send_request(make_request(10'd2, 12'd0, 12'd0, 13'd8, 13'd8));
        write_config(make_cfg(4'd8, 4'd8, 4'd0, 4'd0, 4'd15, 4'd15, 4'd15, 4'd15));
        send_request(make_request(10'd1, 12'd1, 12'd1, 13'd200, 13'd200));
        send_request(make_request(10'd1000, 12'd4095, 12'd4095, 13'd8191, 13'd8191));
        wait_idle();
    endtask

    task automatic test_output_backpressure();
        write_config(make_cfg(4'd3, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1));
        send_idle_pct = 0;
        recv_idle_pct = 0;
        stall_left = 400;
        for (int i = 0; i < 8; i++)
            send_request(make_request(10'(i), 12'(i), 12'(i + 1), 13'd12, 13'd12));
        wait_idle();
    endtask

    task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                       input int items);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (int i = 0; i < items; i++)
        begin
            if (i % CHUNK_ITEMS == 0)
                write_config(random_config());
            send_request(random_request());
        end
        wait_idle();
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        req_valid = 1'b0;
        req = '0;
        send_idle_pct = 18;
        recv_idle_pct = 66;
        stall_left = 0;
        failures = 0;
        taps_checked = 0;
        requests_taken = 0;
        settings_used = 1;
        cycle_count = 0;
        model_cfg = i2c_pkg::CFG_RESET;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_field_extremes();
        test_kernel_sides();
        test_stride_dilation();
        test_output_backpressure();
        test_random_traffic(18, 66, 150);
        test_random_traffic(66, 18, 150);
        test_random_traffic(0, 0, 150);

        if (expected_taps.size() != 0)
            note_failure($sformatf("%0d tap words never arrived", expected_taps.size()));
        $display("Checked %0d tap words from %0d requests over %0d register settings,",
                 taps_checked, requests_taken, settings_used);
        $display("including empty and saturated kernels, zero strides and dilations, stalls.");
        if (failures == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
